>>> sv/ctw_pkg.sv
// Shared constants, payload types and codes for the text console writer.
// No dependencies; the interfaces, the writer and the bench refer to it by scoped names.
package ctw_pkg;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int DEPTH     = ROWS * COLS;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CELL_W    = 16;
  localparam int CHAR_W    = 8;
  localparam int COLOR_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CELL_W-1:0]    BLANK_CELL     = 16'h0720;
  localparam logic [CHAR_W-1:0]    CH_CR          = 8'd13;
  localparam logic [CHAR_W-1:0]    CH_LF          = 8'd10;
  localparam logic                 REQ_PUT        = 1'b0;
  localparam logic                 REQ_READ       = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 1'b1;
  localparam logic [COLOR_W-1:0]   TEXT_COLOR_RST = 4'd8;
  localparam logic [COLOR_W-1:0]   BACK_COLOR_RST = 4'd0;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } req_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } rsp_t;

endpackage

>>> sv/ctw_if.sv
// Request and response channel interfaces for the text console writer.
// Depends on ctw_pkg for the payload types.
interface ctw_req_if;
  logic          valid;
  logic          ready;
  ctw_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ctw_rsp_if;
  logic          valid;
  logic          ready;
  ctw_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ctw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ctw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/text_console_writer.sv
// Text console writer: 25x80 cell screen store with cursor, wrap and scroll.
// Depends on ctw_pkg, ctw_req_if, ctw_rsp_if and ctw_ram.
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    req_type, char_code, read_row, read_col
//   rsp      out  rsp.valid/ready    cell_value, cursor_col, cursor_row, scrolled
//   cfg      in   cfg_wr_en          cfg_index, cfg_data (text_color, back_color)
//
// A put loads the response register on acceptance; a read first passes the registered
// read of the screen RAM and the ST_READ state. A scrolling put then enters ST_FILL:
// the screen is a ring of rows, so a scroll moves the top-row pointer and blanks one
// row through the single RAM write port. After reset a clearing pass writes blanks to
// all ROWS*COLS cells before the first request is taken. The response register holds
// while rsp.ready is low; a new request is taken once it is empty or being drained.
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ctw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ctw_pkg::COLOR_W-1:0]   cfg_data,
  ctw_req_if.sink                       req,
  ctw_rsp_if.source                     rsp
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  localparam logic [ctw_pkg::ROW_W-1:0]  LAST_ROW = ctw_pkg::ROW_W'(ctw_pkg::ROWS - 1);
  localparam logic [ctw_pkg::COL_W:0]    COLS_X   = (ctw_pkg::COL_W + 1)'(ctw_pkg::COLS);
  localparam logic [ctw_pkg::ADDR_W-1:0] LAST_ADR = ctw_pkg::ADDR_W'(ctw_pkg::DEPTH - 1);

  function automatic logic [ctw_pkg::ADDR_W-1:0] cell_addr(
    input logic [ctw_pkg::ROW_W-1:0] row,
    input logic [ctw_pkg::ROW_W-1:0] top_row,
    input logic [ctw_pkg::COL_W-1:0] col
  );
    logic [ctw_pkg::ROW_W:0]   sum;
    logic [ctw_pkg::ROW_W-1:0] phys;
    sum = {1'b0, row} + {1'b0, top_row};
    if (sum >= (ctw_pkg::ROW_W + 1)'(ctw_pkg::ROWS)) begin
      sum = sum - (ctw_pkg::ROW_W + 1)'(ctw_pkg::ROWS);
    end
    phys = sum[ctw_pkg::ROW_W-1:0];
    return ctw_pkg::ADDR_W'(phys) * ctw_pkg::ADDR_W'(ctw_pkg::COLS) + ctw_pkg::ADDR_W'(col);
  endfunction

  logic [1:0]                   state;
  logic [ctw_pkg::COL_W-1:0]    cur_col;
  logic [ctw_pkg::ROW_W-1:0]    cur_row;
  logic [ctw_pkg::ROW_W-1:0]    top;
  logic [ctw_pkg::COLOR_W-1:0]  text_color;
  logic [ctw_pkg::COLOR_W-1:0]  back_color;
  logic [ctw_pkg::ADDR_W-1:0]   sweep_addr;
  logic [ctw_pkg::ADDR_W-1:0]   sweep_end;
  logic                         rd_in_range;
  logic                         out_valid;
  ctw_pkg::rsp_t                out_data;

  logic                         acc;
  logic                         is_read;
  logic                         is_cr;
  logic                         is_lf;
  logic                         is_char;
  logic [ctw_pkg::COL_W:0]      col_inc;
  logic                         newline;
  logic                         do_scroll;
  logic [ctw_pkg::COL_W-1:0]    col_next;
  logic [ctw_pkg::ROW_W-1:0]    row_next;
  logic                         in_range;
  logic                         out_load;

  logic                         ram_wr_en;
  logic [ctw_pkg::ADDR_W-1:0]   ram_wr_addr;
  logic [ctw_pkg::CELL_W-1:0]   ram_wr_data;
  logic                         ram_rd_en;
  logic [ctw_pkg::ADDR_W-1:0]   ram_rd_addr;
  logic [ctw_pkg::CELL_W-1:0]   ram_rd_data;

  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    acc       = req.valid && req.ready;
    is_read   = req.data.req_type == ctw_pkg::REQ_READ;
    is_cr     = req.data.char_code == ctw_pkg::CH_CR;
    is_lf     = req.data.char_code == ctw_pkg::CH_LF;
    is_char   = !is_cr && !is_lf;
    col_inc   = {1'b0, cur_col} + 1'b1;
    newline   = is_lf || (is_char && col_inc == COLS_X);
    do_scroll = newline && cur_row == LAST_ROW;
    col_next  = (is_cr || newline) ? '0 : col_inc[ctw_pkg::COL_W-1:0];
    row_next  = (newline && !do_scroll) ? cur_row + 1'b1 : cur_row;
    in_range  = req.data.read_row < ctw_pkg::ROW_W'(ctw_pkg::ROWS) &&
                req.data.read_col < ctw_pkg::COL_W'(ctw_pkg::COLS);
    out_load  = (acc && !is_read) || (state == ST_READ);
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = sweep_addr;
    ram_wr_data = ctw_pkg::BLANK_CELL;
    if (state == ST_CLEAR || state == ST_FILL) begin
      ram_wr_en = 1'b1;
    end else if (acc && !is_read && is_char) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = cell_addr(cur_row, top, cur_col);
      ram_wr_data = {back_color, text_color, req.data.char_code};
    end
    ram_rd_en   = acc && is_read && in_range;
    ram_rd_addr = cell_addr(req.data.read_row, top, req.data.read_col);
  end

  ctw_ram #(
    .WIDTH (ctw_pkg::CELL_W),
    .DEPTH (ctw_pkg::DEPTH)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= ctw_pkg::TEXT_COLOR_RST;
      back_color <= ctw_pkg::BACK_COLOR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ctw_pkg::REG_TEXT_COLOR: text_color <= cfg_data;
        ctw_pkg::REG_BACK_COLOR: back_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_addr <= '0;
      sweep_end  <= LAST_ADR;
      cur_col    <= '0;
      cur_row    <= '0;
      top        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR, ST_FILL: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == sweep_end) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc && is_read) begin
            rd_in_range <= in_range;
            state       <= ST_READ;
          end else if (acc) begin
            cur_col             <= col_next;
            cur_row             <= row_next;
            out_data.cell_value <= '0;
            out_data.cursor_col <= col_next;
            out_data.cursor_row <= row_next;
            out_data.scrolled   <= do_scroll;
            if (do_scroll) begin
              // blank the old top row, which becomes the new bottom row
              sweep_addr <= cell_addr('0, top, '0);
              sweep_end  <= cell_addr('0, top, ctw_pkg::COL_W'(ctw_pkg::COLS - 1));
              top        <= (top == LAST_ROW) ? '0 : top + 1'b1;
              state      <= ST_FILL;
            end
          end
        end
        ST_READ: begin
          out_data.cell_value <= rd_in_range ? ram_rd_data : '0;
          out_data.cursor_col <= cur_col;
          out_data.cursor_row <= cur_row;
          out_data.scrolled   <= 1'b0;
          state               <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cursor_bounds: assert property (@(posedge clk) disable iff (rst)
    cur_row <= LAST_ROW && cur_col < ctw_pkg::COL_W'(ctw_pkg::COLS))
    else $error("cursor outside the screen");

  a_top_bounds: assert property (@(posedge clk) disable iff (rst)
    top <= LAST_ROW)
    else $error("top row pointer outside the screen");

  a_read_result: assert property (@(posedge clk) disable iff (rst)
    acc && is_read |=> ##1 out_valid)
    else $error("read request gave no response");

  a_scroll_fill: assert property (@(posedge clk) disable iff (rst)
    acc && !is_read && do_scroll |=> state == ST_FILL && out_data.scrolled)
    else $error("scroll did not start a row blank");

endmodule

>>> sim/text_console_writer_tb.sv
// Self-checking bench for text_console_writer: directed cell, cursor, color, wrap and scroll
// cases, then randomized text lines, control bytes and screen reads against a shadow screen.
// Depends on ctw_pkg, ctw_req_if, ctw_rsp_if and the text_console_writer RTL.
module text_console_writer_tb;

  localparam int LIMIT       = 1_000_000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 220;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [ctw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ctw_pkg::COLOR_W-1:0]   cfg_data = '0;

  ctw_req_if req();
  ctw_rsp_if rsp();

  text_console_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [ctw_pkg::CELL_W-1:0]  shadow_screen [ctw_pkg::DEPTH];
  logic [ctw_pkg::COL_W-1:0]   shadow_col;
  logic [ctw_pkg::ROW_W-1:0]   shadow_row;
  logic [ctw_pkg::COLOR_W-1:0] fg_color;
  logic [ctw_pkg::COLOR_W-1:0] bg_color;

  ctw_pkg::rsp_t due_rsp [$];
  ctw_pkg::rsp_t want_rsp;

  int  errors;
  int  n_items;
  int  n_puts;
  int  n_reads;
  int  n_oor;
  int  n_scrolls;
  int  n_checked;
  int  n_color_sets;
  bit  idle_on = 1'b1;
  int  stall_left;

  function automatic void reset_shadow();
    for (int i = 0; i < ctw_pkg::DEPTH; i++) shadow_screen[i] = ctw_pkg::BLANK_CELL;
    shadow_col = '0;
    shadow_row = '0;
    fg_color   = ctw_pkg::TEXT_COLOR_RST;
    bg_color   = ctw_pkg::BACK_COLOR_RST;
  endfunction

  function automatic bit shadow_newline();
    shadow_col = '0;
    if (shadow_row == ctw_pkg::ROW_W'(ctw_pkg::ROWS - 1)) begin
      for (int i = 0; i < (ctw_pkg::ROWS - 1) * ctw_pkg::COLS; i++)
        shadow_screen[i] = shadow_screen[i + ctw_pkg::COLS];
      for (int i = 0; i < ctw_pkg::COLS; i++)
        shadow_screen[(ctw_pkg::ROWS - 1) * ctw_pkg::COLS + i] = ctw_pkg::BLANK_CELL;
      return 1'b1;
    end
    shadow_row = shadow_row + 1'b1;
    return 1'b0;
  endfunction

  function automatic ctw_pkg::rsp_t apply_to_shadow(input ctw_pkg::req_t r);
    ctw_pkg::rsp_t o;
    o = '0;
    if (r.req_type == ctw_pkg::REQ_READ) begin
      if (r.read_row < ctw_pkg::ROWS && r.read_col < ctw_pkg::COLS)
        o.cell_value = shadow_screen[r.read_row * ctw_pkg::COLS + r.read_col];
    end else if (r.char_code == ctw_pkg::CH_CR) begin
      shadow_col = '0;
    end else if (r.char_code == ctw_pkg::CH_LF) begin
      o.scrolled = shadow_newline();
    end else begin
      shadow_screen[shadow_row * ctw_pkg::COLS + shadow_col] =
        {bg_color, fg_color, r.char_code};
      if (shadow_col == ctw_pkg::COL_W'(ctw_pkg::COLS - 1)) o.scrolled = shadow_newline();
      else shadow_col = shadow_col + 1'b1;
    end
    o.cursor_col = shadow_col;
    o.cursor_row = shadow_row;
    return o;
  endfunction

  function automatic ctw_pkg::req_t put_item(input logic [ctw_pkg::CHAR_W-1:0] c);
    ctw_pkg::req_t r;
    r.req_type  = ctw_pkg::REQ_PUT;
    r.char_code = c;
    r.read_row  = ctw_pkg::ROW_W'($urandom);
    r.read_col  = ctw_pkg::COL_W'($urandom);
    return r;
  endfunction

  function automatic ctw_pkg::req_t read_item(input int row, input int col);
    ctw_pkg::req_t r;
    r.req_type  = ctw_pkg::REQ_READ;
    r.char_code = ctw_pkg::CHAR_W'($urandom);
    r.read_row  = ctw_pkg::ROW_W'(row);
    r.read_col  = ctw_pkg::COL_W'(col);
    return r;
  endfunction

  function automatic logic [ctw_pkg::CHAR_W-1:0] text_char();
    logic [ctw_pkg::CHAR_W-1:0] c;
    if ($urandom_range(0, 9) < 7) return ctw_pkg::CHAR_W'($urandom_range(32, 126));
    do c = ctw_pkg::CHAR_W'($urandom); while (c == ctw_pkg::CH_CR || c == ctw_pkg::CH_LF);
    return c;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got 0x%0h want 0x%0h", field, got, want);
    errors++;
  endtask

  task automatic send_req(input ctw_pkg::req_t r);
    int            gap;
    ctw_pkg::rsp_t want;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    do @(posedge clk); while (!req.ready);
    want = apply_to_shadow(r);
    due_rsp.push_back(want);
    n_items++;
    if (r.req_type == ctw_pkg::REQ_READ) begin
      n_reads++;
      if (!(r.read_row < ctw_pkg::ROWS && r.read_col < ctw_pkg::COLS)) n_oor++;
    end else begin
      n_puts++;
    end
    n_scrolls += want.scrolled;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req.valid <= 1'b0;
    while (due_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ctw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ctw_pkg::COLOR_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == ctw_pkg::REG_TEXT_COLOR) fg_color = val;
    else bg_color = val;
    n_color_sets++;
  endtask

  task automatic set_colors(input logic [ctw_pkg::COLOR_W-1:0] fg,
                            input logic [ctw_pkg::COLOR_W-1:0] bg);
    write_reg(ctw_pkg::REG_TEXT_COLOR, fg);
    write_reg(ctw_pkg::REG_BACK_COLOR, bg);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (due_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding", rsp.data.cell_value, 0);
      end else begin
        want_rsp = due_rsp.pop_front();
        n_checked++;
        if (rsp.data.cell_value !== want_rsp.cell_value)
          report_mismatch("cell_value", rsp.data.cell_value, want_rsp.cell_value);
        if (rsp.data.cursor_col !== want_rsp.cursor_col)
          report_mismatch("cursor_col", rsp.data.cursor_col, want_rsp.cursor_col);
        if (rsp.data.cursor_row !== want_rsp.cursor_row)
          report_mismatch("cursor_row", rsp.data.cursor_row, want_rsp.cursor_row);
        if (rsp.data.scrolled !== want_rsp.scrolled)
          report_mismatch("scrolled", rsp.data.scrolled, want_rsp.scrolled);
      end
    end
  end

  task automatic test_blank_screen();
    send_req(read_item(0, 0));
    send_req(read_item(ctw_pkg::ROWS - 1, ctw_pkg::COLS - 1));
    send_req(read_item(0, ctw_pkg::COLS - 1));
    send_req(read_item(ctw_pkg::ROWS, 0));
    send_req(read_item(31, 127));
    send_req(read_item(0, ctw_pkg::COLS));
  endtask

  task automatic test_put_chars();
    send_req(put_item(8'h41));
    send_req(put_item(8'h00));
    send_req(put_item(8'hFF));
    send_req(put_item(8'h80));
    send_req(put_item(8'h7F));
    send_req(read_item(0, 0));
    send_req(read_item(0, 2));
  endtask

  task automatic test_cr_lf();
    send_req(put_item(ctw_pkg::CH_CR));
    send_req(put_item(8'h2A));
    send_req(put_item(ctw_pkg::CH_LF));
    send_req(put_item(ctw_pkg::CH_LF));
    send_req(read_item(0, 0));
    send_req(read_item(2, 0));
  endtask

  task automatic test_colors();
    set_colors(4'hF, 4'hF);
    send_req(put_item(8'h58));
    set_colors(4'h0, 4'h0);
    send_req(put_item(8'h59));
    send_req(read_item(2, 0));
    send_req(read_item(2, 1));
  endtask

  task automatic test_wrap_scroll();
    set_colors(ctw_pkg::COLOR_W'($urandom), ctw_pkg::COLOR_W'($urandom));
    send_req(put_item(ctw_pkg::CH_CR));
    repeat (ctw_pkg::COLS) send_req(put_item(text_char()));
    send_req(read_item(shadow_row - 1, ctw_pkg::COLS - 1));
    while (shadow_row != ctw_pkg::ROW_W'(ctw_pkg::ROWS - 1))
      send_req(put_item(ctw_pkg::CH_LF));
    send_req(put_item(ctw_pkg::CH_LF));
    repeat (ctw_pkg::COLS) send_req(put_item(text_char()));
    send_req(read_item(ctw_pkg::ROWS - 1, 0));
    send_req(read_item(ctw_pkg::ROWS - 2, ctw_pkg::COLS - 1));
    send_req(read_item(ctw_pkg::ROWS - 2, 0));
  endtask

  task automatic test_random_traffic();
    int            phase_end;
    int            kind;
    int            len;
    ctw_pkg::req_t r;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1: set_colors(4'hF, 4'h0);
        2: set_colors(4'h0, 4'hF);
        default: set_colors(ctw_pkg::COLOR_W'($urandom), ctw_pkg::COLOR_W'($urandom));
      endcase
      if (ph == PHASES - 1) idle_on = 1'b0;
      phase_end = n_items + PHASE_ITEMS;
      while (n_items < phase_end) begin
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 40);
          repeat (len) send_req(put_item(text_char()));
          case ($urandom_range(0, 3))
            0: begin
              send_req(put_item(ctw_pkg::CH_CR));
              send_req(put_item(ctw_pkg::CH_LF));
            end
            1: send_req(put_item(ctw_pkg::CH_LF));
            2: send_req(put_item(ctw_pkg::CH_CR));
            default: ;
          endcase
        end else if (kind < 17) begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
              0: send_req(read_item(shadow_row, $urandom_range(0, ctw_pkg::COLS - 1)));
              1: send_req(read_item($urandom_range(0, ctw_pkg::ROWS - 1),
                                    $urandom_range(0, ctw_pkg::COLS - 1)));
              default: send_req(read_item($urandom_range(0, 31), $urandom_range(0, 127)));
            endcase
          end
        end else if (kind < 19) begin
          send_req(put_item($urandom_range(0, 1) ? ctw_pkg::CH_CR : ctw_pkg::CH_LF));
        end else begin
          r.req_type  = 1'($urandom);
          r.char_code = ctw_pkg::CHAR_W'($urandom);
          r.read_row  = ctw_pkg::ROW_W'($urandom);
          r.read_col  = ctw_pkg::COL_W'($urandom);
          send_req(r);
        end
        if (ph == 2 && n_items == phase_end - PHASE_ITEMS / 2) wait_drained();
      end
    end
  endtask

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    req.valid = 1'b0;
    req.data  = '0;
    rsp.ready = 1'b0;
    reset_shadow();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_blank_screen();
    test_put_chars();
    test_cr_lf();
    test_colors();
    test_wrap_scroll();
    test_random_traffic();

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d puts with %0d scrolls and %0d reads, %0d of them off screen",
             n_puts, n_scrolls, n_reads, n_oor);
    $display("%0d results checked over %0d color writes, %0d mismatches",
             n_checked, n_color_sets, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
